### rtl/core/bresenham_line_pixel_stepper_defines.svh
// Assertion macros shared by the line stepper modules.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define BLPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define BLPS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define BLPS_ASSERT(label, clk, rst_n, prop, msg)
`define BLPS_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

### rtl/core/blps_pkg.sv
package blps_pkg;

    // Default sizing of the coordinate path and the screen limit.
    localparam int COORD_BITS_DEF = 16;
    localparam int SCREEN_MAX_DEF = 4096;

    // Fixed field widths.
    localparam int COLOUR_W   = 32;
    localparam int CFG_REG_W  = 13;
    localparam int CFG_ADDR_W = 1;

    // Entries in the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Reset values of the screen size registers.
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Input item kinds, carried on s_tuser.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### rtl/core/blps_fifo.sv
`include "bresenham_line_pixel_stepper_defines.svh"

module blps_fifo
    import blps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_fire;
    logic             rd_fire;

    // Handshake status on both sides.
    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage; needs no reset.
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `BLPS_ASSERT_NEVER(a_fifo_overflow, aclk, aresetn, count_reg > CNT_W'(DEPTH), "fifo count beyond depth")
    `BLPS_ASSERT(a_fifo_count_up, aclk, aresetn, (wr_fire && !rd_fire) |=> (count_reg == $past(count_reg) + 1'b1), "fifo count failed to grow on write")
    `BLPS_ASSERT(a_fifo_ptr_gap, aclk, aresetn, ((count_reg != '0) && (count_reg != CNT_W'(DEPTH))) |-> (wr_ptr_reg != rd_ptr_reg), "fifo pointers disagree with count")

endmodule

### rtl/core/blps_front.sv
module blps_front
    import blps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_DATA_W = ((4 * COORD_BITS + COLOUR_W + 7) / 8) * 8,
    localparam int CMD_W = 6 * COORD_BITS + COLOUR_W + 3
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                q_wr_valid,
    input  logic                q_wr_ready,
    output logic [CMD_W-1:0]    q_wr_data
);

    localparam int C = COORD_BITS;

    logic [C-1:0]        in_sx;
    logic [C-1:0]        in_sy;
    logic [C-1:0]        in_ex;
    logic [C-1:0]        in_ey;
    logic [COLOUR_W-1:0] in_colour;
    logic [C:0]          x_fwd;
    logic [C:0]          x_bwd;
    logic [C:0]          y_fwd;
    logic [C:0]          y_bwd;
    logic                ex_lt_sx;
    logic                sx_lt_ex;
    logic                ey_lt_sy;
    logic                sy_lt_ey;
    logic                s_fire;

    logic                stg_valid_reg;
    logic                stg_is_load_reg;
    logic [C-1:0]        stg_sx_reg;
    logic [C-1:0]        stg_sy_reg;
    logic [C-1:0]        stg_ex_reg;
    logic [C-1:0]        stg_ey_reg;
    logic [C-1:0]        stg_dx_reg;
    logic [C-1:0]        stg_dy_reg;
    logic                stg_ex_lt_sx_reg;
    logic                stg_sx_lt_ex_reg;
    logic                stg_ey_lt_sy_reg;
    logic                stg_sy_lt_ey_reg;
    logic [COLOUR_W-1:0] stg_colour_reg;

    logic                x_major;
    logic                swap;
    logic                minor_neg;
    logic [C-1:0]        wsx;
    logic [C-1:0]        wsy;
    logic [C-1:0]        wex;
    logic [C-1:0]        wey;

    // Field unpacking, lowest field first.
    assign in_sx     = s_tdata[0 +: C];
    assign in_sy     = s_tdata[C +: C];
    assign in_ex     = s_tdata[2 * C +: C];
    assign in_ey     = s_tdata[3 * C +: C];
    assign in_colour = s_tdata[4 * C +: COLOUR_W];

    // Endpoint differences in both directions and their orderings.
    assign x_fwd    = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
    assign x_bwd    = {in_sx[C-1], in_sx} - {in_ex[C-1], in_ex};
    assign y_fwd    = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
    assign y_bwd    = {in_sy[C-1], in_sy} - {in_ey[C-1], in_ey};
    assign ex_lt_sx = $signed(in_ex) < $signed(in_sx);
    assign sx_lt_ex = $signed(in_sx) < $signed(in_ex);
    assign ey_lt_sy = $signed(in_ey) < $signed(in_sy);
    assign sy_lt_ey = $signed(in_sy) < $signed(in_ey);

    // The stage takes a new transfer when empty or when the queue takes its entry.
    assign s_tready = !stg_valid_reg || q_wr_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                stg_valid_reg <= 1'b1;
            end else if (q_wr_ready) begin
                stg_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                stg_is_load_reg  <= (s_tuser == MODE_LOAD);
                stg_sx_reg       <= in_sx;
                stg_sy_reg       <= in_sy;
                stg_ex_reg       <= in_ex;
                stg_ey_reg       <= in_ey;
                stg_dx_reg       <= ex_lt_sx ? x_bwd[C-1:0] : x_fwd[C-1:0];
                stg_dy_reg       <= ey_lt_sy ? y_bwd[C-1:0] : y_fwd[C-1:0];
                stg_ex_lt_sx_reg <= ex_lt_sx;
                stg_sx_lt_ex_reg <= sx_lt_ex;
                stg_ey_lt_sy_reg <= ey_lt_sy;
                stg_sy_lt_ey_reg <= sy_lt_ey;
                stg_colour_reg   <= in_colour;
            end
        end
    end

    // Major axis choice and walk ordering of the endpoints.
    assign x_major = stg_dx_reg > stg_dy_reg;
    assign swap    = x_major ? stg_ex_lt_sx_reg : stg_ey_lt_sy_reg;
    assign wsx     = swap ? stg_ex_reg : stg_sx_reg;
    assign wsy     = swap ? stg_ey_reg : stg_sy_reg;
    assign wex     = swap ? stg_sx_reg : stg_ex_reg;
    assign wey     = swap ? stg_sy_reg : stg_ey_reg;

    // The minor axis runs downward when the walk-ordered end lies below the start.
    always_comb begin
        if (x_major) begin
            minor_neg = swap ? stg_sy_lt_ey_reg : stg_ey_lt_sy_reg;
        end else begin
            minor_neg = swap ? stg_sx_lt_ex_reg : stg_ex_lt_sx_reg;
        end
    end

    assign q_wr_valid = stg_valid_reg;
    assign q_wr_data  = {stg_colour_reg, minor_neg, x_major, stg_dy_reg, stg_dx_reg,
                         wey, wex, wsy, wsx, stg_is_load_reg};

endmodule

### rtl/core/blps_back.sv
`include "bresenham_line_pixel_stepper_defines.svh"

module blps_back
    import blps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SCREEN_MAX = SCREEN_MAX_DEF,
    localparam int CMD_W = 6 * COORD_BITS + COLOUR_W + 3,
    localparam int SCR_W = $clog2(SCREEN_MAX + 1),
    localparam int M_DATA_W = ((2 * COORD_BITS + COLOUR_W + 7) / 8) * 8
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [SCR_W-1:0]    scr_width,
    input  logic [SCR_W-1:0]    scr_height,
    input  logic                q_rd_valid,
    output logic                q_rd_ready,
    input  logic [CMD_W-1:0]    q_rd_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int CMP_W = (C > SCR_W) ? C : SCR_W;

    typedef enum logic [1:0] {
        PH_WALK       = 2'd0,
        PH_ECHO_START = 2'd1,
        PH_ECHO_END   = 2'd2
    } phase_t;

    // Command fields.
    logic                cmd_is_load;
    logic [C-1:0]        cmd_sx;
    logic [C-1:0]        cmd_sy;
    logic [C-1:0]        cmd_ex;
    logic [C-1:0]        cmd_ey;
    logic [C-1:0]        cmd_dx;
    logic [C-1:0]        cmd_dy;
    logic                cmd_x_major;
    logic                cmd_minor_neg;
    logic [COLOUR_W-1:0] cmd_colour;

    // Walk state.
    logic                busy_reg;
    phase_t              phase_reg;
    logic [C-1:0]        cur_x_reg;
    logic [C-1:0]        cur_y_reg;
    logic [C:0]          err_reg;
    logic [C-1:0]        dx_reg;
    logic [C-1:0]        dy_reg;
    logic                x_major_reg;
    logic                minor_neg_reg;
    logic [C-1:0]        walk_stop_reg;
    logic [C-1:0]        echo_sx_reg;
    logic [C-1:0]        echo_sy_reg;
    logic [C-1:0]        echo_ex_reg;
    logic [C-1:0]        echo_ey_reg;
    logic [COLOUR_W-1:0] colour_reg;

    // Output register.
    logic                m_valid_reg;
    logic [C-1:0]        m_x_reg;
    logic [C-1:0]        m_y_reg;
    logic [COLOUR_W-1:0] m_colour_reg;
    logic                m_visible_reg;
    logic                m_last_reg;

    logic                pop;
    logic                emit_fire;
    logic [C-1:0]        major;
    logic [C-1:0]        minor;
    logic [C:0]          major_ext;
    logic [C-1:0]        major_pos;
    logic [C-1:0]        minor_pos;
    logic [C-1:0]        minor_next;
    logic [C-1:0]        major_next;
    logic                at_end;
    logic [C:0]          err_sum;
    logic                step_minor;
    logic [C:0]          err_next;
    logic [C-1:0]        emit_x;
    logic [C-1:0]        emit_y;
    logic                emit_visible;

    assign cmd_is_load   = q_rd_data[0];
    assign cmd_sx        = q_rd_data[1 +: C];
    assign cmd_sy        = q_rd_data[1 + C +: C];
    assign cmd_ex        = q_rd_data[1 + 2 * C +: C];
    assign cmd_ey        = q_rd_data[1 + 3 * C +: C];
    assign cmd_dx        = q_rd_data[1 + 4 * C +: C];
    assign cmd_dy        = q_rd_data[1 + 5 * C +: C];
    assign cmd_x_major   = q_rd_data[1 + 6 * C];
    assign cmd_minor_neg = q_rd_data[2 + 6 * C];
    assign cmd_colour    = q_rd_data[3 + 6 * C +: COLOUR_W];

    // A command is taken whenever the output register is free or being drained.
    assign q_rd_ready = !m_valid_reg || m_tready;
    assign pop        = q_rd_valid && q_rd_ready;
    assign emit_fire  = pop && !cmd_is_load && busy_reg &&
                        (phase_reg inside {PH_WALK, PH_ECHO_START, PH_ECHO_END});

    // One step of the walk: accumulate, compare, conditionally subtract.
    assign major      = x_major_reg ? dx_reg : dy_reg;
    assign minor      = x_major_reg ? dy_reg : dx_reg;
    assign major_ext  = {1'b0, major};
    assign major_pos  = x_major_reg ? cur_x_reg : cur_y_reg;
    assign minor_pos  = x_major_reg ? cur_y_reg : cur_x_reg;
    assign at_end     = $signed(major_pos) >= $signed(walk_stop_reg);
    assign err_sum    = err_reg + {1'b0, minor};
    assign step_minor = err_sum >= major_ext;
    assign err_next   = step_minor ? err_sum - major_ext : err_sum;
    assign minor_next = minor_neg_reg ? minor_pos - 1'b1 : minor_pos + 1'b1;
    assign major_next = major_pos + 1'b1;

    // Pixel position for the current phase.
    always_comb begin
        case (phase_reg)
            PH_WALK: begin
                emit_x = cur_x_reg;
                emit_y = cur_y_reg;
            end
            PH_ECHO_START: begin
                emit_x = echo_sx_reg;
                emit_y = echo_sy_reg;
            end
            default: begin
                emit_x = echo_ex_reg;
                emit_y = echo_ey_reg;
            end
        endcase
    end

    // Visible when both coordinates are non-negative and below the screen size.
    assign emit_visible = !emit_x[C-1] && !emit_y[C-1] &&
                          (CMP_W'(emit_x) < CMP_W'(scr_width)) &&
                          (CMP_W'(emit_y) < CMP_W'(scr_height));

    // Sequencer state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_WALK;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit_fire) begin
                m_valid_reg   <= 1'b1;
                m_x_reg       <= emit_x;
                m_y_reg       <= emit_y;
                m_colour_reg  <= colour_reg;
                m_visible_reg <= emit_visible;
                m_last_reg    <= (phase_reg == PH_ECHO_END);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (pop && cmd_is_load) begin
                // A load replaces any line in progress.
                busy_reg      <= 1'b1;
                phase_reg     <= PH_WALK;
                cur_x_reg     <= cmd_sx;
                cur_y_reg     <= cmd_sy;
                dx_reg        <= cmd_dx;
                dy_reg        <= cmd_dy;
                x_major_reg   <= cmd_x_major;
                minor_neg_reg <= cmd_minor_neg;
                walk_stop_reg <= cmd_x_major ? cmd_ex : cmd_ey;
                err_reg       <= {1'b0, (cmd_x_major ? cmd_dx : cmd_dy)} >> 1;
                echo_sx_reg   <= cmd_sx;
                echo_sy_reg   <= cmd_sy;
                echo_ex_reg   <= cmd_ex;
                echo_ey_reg   <= cmd_ey;
                colour_reg    <= cmd_colour;
            end else if (pop && busy_reg) begin
                case (phase_reg)
                    PH_WALK: begin
                        if (at_end) begin
                            phase_reg <= PH_ECHO_START;
                        end else begin
                            err_reg <= err_next;
                            if (x_major_reg) begin
                                cur_x_reg <= major_next;
                                if (step_minor) begin
                                    cur_y_reg <= minor_next;
                                end
                            end else begin
                                cur_y_reg <= major_next;
                                if (step_minor) begin
                                    cur_x_reg <= minor_next;
                                end
                            end
                        end
                    end
                    PH_ECHO_START: begin
                        phase_reg <= PH_ECHO_END;
                    end
                    PH_ECHO_END: begin
                        phase_reg <= PH_WALK;
                        busy_reg  <= 1'b0;
                    end
                    default: begin
                        phase_reg <= PH_WALK;
                        busy_reg  <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_colour_reg, m_y_reg, m_x_reg});
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_visible_reg;

    `BLPS_ASSERT(a_idle_in_walk, aclk, aresetn, !busy_reg |-> (phase_reg == PH_WALK), "idle stepper left in an echo phase")
    `BLPS_ASSERT(a_err_below_major, aclk, aresetn, (busy_reg && (phase_reg == PH_WALK) && (major != '0)) |-> (err_reg < major_ext), "error accumulator reached the major delta")
    `BLPS_ASSERT(a_pixel_from_pop, aclk, aresetn, $rose(m_valid_reg) |-> $past(pop), "pixel appeared without a command taken")

endmodule

### rtl/core/bresenham_line_pixel_stepper.sv
// Bresenham line stepper. A load transfer (s_tuser low) arms a line from two
// signed endpoints and a colour and yields no pixel; each tick transfer
// (s_tuser high) yields one pixel: the walk along the major axis gives
// max(|dx|,|dy|)+1 pixels, then the walk-ordered start point and end point are
// echoed, the end point with m_tlast set. A tick with no line armed yields
// nothing. m_tuser flags a pixel inside the configured screen size. The block
// sustains one input transfer per cycle, loads and ticks alike, while the pixel
// output is not stalled, since the back end performs one walk step (accumulate,
// compare, conditional subtract) per cycle. A tick's pixel passes through the
// front register, a queue entry and the output register before it is presented
// on m_tvalid. The front end keeps taking transfers while the output is stalled
// until its register and the four-entry queue are full. The screen size
// registers must be written only while idle; the block does not enforce this.
module bresenham_line_pixel_stepper
    import blps_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SCREEN_MAX = SCREEN_MAX_DEF,
    localparam int S_DATA_W = ((4 * COORD_BITS + COLOUR_W + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_BITS + COLOUR_W + 7) / 8) * 8
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_REG_W-1:0]  cfg_wr_data,
    // Input channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // start_x, start_y, end_x, end_y, line_colour
    input  logic                  s_tuser,   // mode
    // Pixel channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // pixel_x, pixel_y, pixel_colour
    output logic                  m_tlast,
    output logic                  m_tuser    // visible
);

    localparam int CMD_W   = 6 * COORD_BITS + COLOUR_W + 3;
    localparam int SCR_W   = $clog2(SCREEN_MAX + 1);
    localparam int CLAMP_W = (CFG_REG_W > SCR_W) ? CFG_REG_W : SCR_W;
    localparam logic [SCR_W-1:0] WIDTH_RST =
        SCR_W'((WIDTH_RESET > SCREEN_MAX) ? SCREEN_MAX : WIDTH_RESET);
    localparam logic [SCR_W-1:0] HEIGHT_RST =
        SCR_W'((HEIGHT_RESET > SCREEN_MAX) ? SCREEN_MAX : HEIGHT_RESET);

    logic [SCR_W-1:0] scr_width_reg;
    logic [SCR_W-1:0] scr_height_reg;
    logic [SCR_W-1:0] cfg_clamped;
    logic             q_wr_valid;
    logic             q_wr_ready;
    logic [CMD_W-1:0] q_wr_data;
    logic             q_rd_valid;
    logic             q_rd_ready;
    logic [CMD_W-1:0] q_rd_data;

    // Screen sizes are held already limited to the largest supported screen.
    assign cfg_clamped = (CLAMP_W'(cfg_wr_data) > CLAMP_W'(SCREEN_MAX)) ?
                         SCR_W'(SCREEN_MAX) : SCR_W'(cfg_wr_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_width_reg  <= WIDTH_RST;
            scr_height_reg <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_SCREEN_WIDTH:  scr_width_reg  <= cfg_clamped;
                REG_SCREEN_HEIGHT: scr_height_reg <= cfg_clamped;
                default: begin
                end
            endcase
        end
    end

    // Front end: takes transfers and prepares line commands.
    blps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_data  (q_wr_data)
    );

    // Command queue between the two ends.
    blps_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    // Back end: runs the walk and drives the pixel channel.
    blps_back #(
        .COORD_BITS (COORD_BITS),
        .SCREEN_MAX (SCREEN_MAX)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scr_width  (scr_width_reg),
        .scr_height (scr_height_reg),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_data  (q_rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
